// ===== hdl/gll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gll_pkg
// Shared types and constants of the GLL position sentence parser.
// ----------------------------------------------------------------------------
package gll_pkg;

    localparam int FRAC_DIGITS_DEF = 5;
    localparam int FRAC_W          = 17;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Field numbers inside a sentence, counted from the header remainder.
    localparam logic [2:0] FLD_LAT  = 3'd1;
    localparam logic [2:0] FLD_NS   = 3'd2;
    localparam logic [2:0] FLD_LON  = 3'd3;
    localparam logic [2:0] FLD_EW   = 3'd4;
    localparam logic [2:0] FLD_TIME = 3'd5;
    localparam logic [2:0] FLD_LAST = 3'd7;

    // One finished field, handed from the byte front end to the evaluator.
    typedef struct packed {
        logic [2:0]        fld;
        logic              term;
        logic              bad;
        logic [9:0]        deg;
        logic [6:0]        mm;
        logic [FRAC_W-1:0] frac;
        logic [2:0]        fcnt;
        logic [7:0]        hr;
        logic [6:0]        mn;
        logic [6:0]        ss;
        logic [7:0]        side;
        logic [4:0]        mask;
    } t_cmd;

endpackage

// ===== hdl/nmea_gll_position_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_gll_position_parser_top
// GLL position sentence parser: bytes in, one position record per sentence.
// ----------------------------------------------------------------------------
// The block takes one ASCII byte per transaction and accepts a byte every
// cycle. It looks for the header $GPGLL, splits the sentence at commas and
// converts latitude and longitude (ddmm.mmmmm) to degrees times 100000 with
// exact integer arithmetic, saturating at 2^25-1; it keeps both hemisphere
// bytes and hour, minute and second of the time field. A '*', a control
// byte or a byte above 'z' ends the sentence and yields one output
// transaction; fields that did not appear keep the values of earlier
// sentences, and present_mask tells which fields were reached. A numeric
// field with a foreign character reads as zero. Inside the block a byte front
// end accumulates digits and hands each finished field to a short queue; a
// three-stage evaluator (scaling multiplies, a reciprocal divide by 60, then
// add and saturate) drains it at one field per cycle while the output is not
// held by i_stall. The input stalls only when the field queue is full, which
// happens only while the output is held by i_stall.
// ----------------------------------------------------------------------------
module nmea_gll_position_parser_top #(
    parameter int FRAC_DIGITS = gll_pkg::FRAC_DIGITS_DEF,
    parameter int QUEUE_DEPTH = gll_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [24:0] o_lat_value,
    output logic [7:0]  o_lat_side,
    output logic [24:0] o_lon_value,
    output logic [7:0]  o_lon_side,
    output logic [7:0]  o_utc_hour,
    output logic [6:0]  o_utc_minute,
    output logic [6:0]  o_utc_second,
    output logic [4:0]  o_present_mask
);
    import gll_pkg::*;

    t_cmd front_cmd, head_cmd;
    logic push, pop, full, empty, accept;

    // A byte is taken whenever the queue has room for the field it may end.
    assign o_stall = full;
    assign accept  = i_valid && !full;

    gll_front #(.FRAC_DIGITS(FRAC_DIGITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    gll_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (head_cmd)
    );

    gll_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_have         (!empty),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_lat_value    (o_lat_value),
        .o_lat_side     (o_lat_side),
        .o_lon_value    (o_lon_value),
        .o_lon_side     (o_lon_side),
        .o_utc_hour     (o_utc_hour),
        .o_utc_minute   (o_utc_minute),
        .o_utc_second   (o_utc_second),
        .o_present_mask (o_present_mask)
    );

endmodule

// ===== hdl/gll_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gll_front
// Header search, field splitting and digit accumulation, one byte a cycle while i_accept is high.
// ----------------------------------------------------------------------------
module gll_front #(
    parameter int FRAC_DIGITS = gll_pkg::FRAC_DIGITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_rx_byte,
    output logic         o_push,
    output gll_pkg::t_cmd o_cmd
);
    import gll_pkg::*;

    localparam logic [2:0] HDR_LEN = 3'd6;
    localparam logic [2:0] FRAC_MAX = 3'(FRAC_DIGITS);

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h4C;
            3'd5:    c = 8'h4C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    logic [2:0]        r_hm, n_hm;
    logic              r_in, n_in;
    logic [2:0]        r_fn, n_fn;
    logic [31:0]       r_int, n_int;
    logic              r_sat, n_sat;
    logic [15:0]       r_nib, n_nib;
    logic [9:0]        r_deg, n_deg;
    logic [7:0]        r_hr, n_hr;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [2:0]        r_fcnt, n_fcnt;
    logic              r_pt, n_pt;
    logic              r_bad, n_bad;
    logic [7:0]        r_first, n_first;
    logic [4:0]        r_seen, n_seen;

    logic        term, delim, is_digit;
    logic [3:0]  dig;
    logic [34:0] int_prod;
    logic [13:0] deg_tmp;
    logic [11:0] hr_tmp;
    logic [2:0]  fn_inc;

    always_comb begin
        term     = (i_rx_byte == 8'h2A) || (i_rx_byte < 8'h20) || (i_rx_byte > 8'h7A);
        delim    = term || (i_rx_byte == 8'h2C);
        is_digit = (i_rx_byte >= 8'h30) && (i_rx_byte <= 8'h39);
        dig      = 4'(i_rx_byte - 8'h30);
        int_prod = {3'b000, r_int} * 35'd10 + {31'd0, dig};
        deg_tmp  = {4'd0, r_deg} * 14'd10 + {10'd0, r_nib[7:4]};
        hr_tmp   = {4'd0, r_hr} * 12'd10 + {8'd0, r_nib[15:12]};
        fn_inc   = (r_fn < FLD_LAST) ? r_fn + 3'd1 : r_fn;

        n_hm = r_hm;  n_in = r_in;   n_fn = r_fn;     n_int = r_int;
        n_sat = r_sat; n_nib = r_nib; n_deg = r_deg;  n_hr = r_hr;
        n_frac = r_frac; n_fcnt = r_fcnt; n_pt = r_pt; n_bad = r_bad;
        n_first = r_first; n_seen = r_seen;
        o_push = 1'b0;

        if (i_accept) begin
            if (!r_in) begin
                if (i_rx_byte == hdr_char(r_hm)) begin
                    n_hm = r_hm + 3'd1;
                end else if (i_rx_byte == 8'h24) begin
                    n_hm = 3'd1;
                end else begin
                    n_hm = 3'd0;
                end
                if (n_hm == HDR_LEN) begin
                    n_in   = 1'b1;
                    n_hm   = 3'd0;
                    n_fn   = 3'd0;
                    n_seen = 5'd0;
                end
            end else if (delim) begin
                o_push = 1'b1;
                if (term) begin
                    n_in = 1'b0;
                    n_fn = 3'd0;
                end else begin
                    n_fn = fn_inc;
                    if (fn_inc >= FLD_LAT && fn_inc <= FLD_TIME) begin
                        n_seen = r_seen | 5'(5'd1 << (fn_inc - 3'd1));
                    end
                end
            end else begin
                if (r_first == 8'h00) begin
                    n_first = i_rx_byte;
                end
                if (is_digit) begin
                    if (r_pt) begin
                        if (r_fcnt < FRAC_MAX) begin
                            n_frac = FRAC_W'({r_frac, 3'b000} + {2'b00, r_frac, 1'b0}
                                             + {{(FRAC_W-1){1'b0}}, dig});
                            n_fcnt = r_fcnt + 3'd1;
                        end
                    end else if (!r_sat) begin
                        if (int_prod > 35'h0FFFFFFFF) begin
                            n_int = 32'hFFFFFFFF;
                            n_sat = 1'b1;
                        end else begin
                            n_int = int_prod[31:0];
                        end
                        n_nib = {r_nib[11:0], dig};
                        n_deg = (deg_tmp > 14'd1023) ? 10'd1023 : deg_tmp[9:0];
                        n_hr  = (hr_tmp > 12'd255) ? 8'd255 : hr_tmp[7:0];
                    end
                end else if (i_rx_byte == 8'h2E) begin
                    if (r_pt) begin
                        n_bad = 1'b1;
                    end else begin
                        n_pt = 1'b1;
                    end
                end else begin
                    n_bad = 1'b1;
                end
            end

            // Every field boundary and a new sentence start from a clean field.
            if ((!r_in && n_in) || (r_in && delim)) begin
                n_int = 32'd0;  n_sat = 1'b0; n_nib = 16'd0; n_deg = 10'd0;
                n_hr = 8'd0;    n_frac = '0;  n_fcnt = 3'd0; n_pt = 1'b0;
                n_bad = 1'b0;   n_first = 8'h00;
            end
        end
    end

    always_comb begin
        o_cmd.fld  = r_fn;
        o_cmd.term = term;
        o_cmd.bad  = r_bad;
        o_cmd.deg  = r_deg;
        o_cmd.mm   = 7'({3'd0, r_nib[7:4]} * 7'd10 + {3'd0, r_nib[3:0]});
        o_cmd.frac = r_frac;
        o_cmd.fcnt = r_fcnt;
        o_cmd.side = (r_first != 8'h00) ? r_first : i_rx_byte;
        o_cmd.mask = r_seen;
        if (r_sat) begin
            // A saturated integer reads as 4294967295.
            o_cmd.hr = 8'd255;
            o_cmd.mn = 7'd72;
            o_cmd.ss = 7'd95;
        end else begin
            o_cmd.hr = r_hr;
            o_cmd.mn = 7'({3'd0, r_nib[15:12]} * 7'd10 + {3'd0, r_nib[11:8]});
            o_cmd.ss = 7'({3'd0, r_nib[7:4]} * 7'd10 + {3'd0, r_nib[3:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hm <= 3'd0; r_in <= 1'b0; r_fn <= 3'd0; r_int <= 32'd0; r_sat <= 1'b0;
            r_nib <= 16'd0; r_deg <= 10'd0; r_hr <= 8'd0; r_frac <= '0; r_fcnt <= 3'd0;
            r_pt <= 1'b0; r_bad <= 1'b0; r_first <= 8'h00; r_seen <= 5'd0;
        end else begin
            r_hm <= n_hm; r_in <= n_in; r_fn <= n_fn; r_int <= n_int; r_sat <= n_sat;
            r_nib <= n_nib; r_deg <= n_deg; r_hr <= n_hr; r_frac <= n_frac;
            r_fcnt <= n_fcnt; r_pt <= n_pt; r_bad <= n_bad; r_first <= n_first;
            r_seen <= n_seen;
        end
    end

endmodule

// ===== hdl/gll_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gll_queue
// Small first-in first-out queue of finished fields.
// ----------------------------------------------------------------------------
module gll_queue #(
    parameter int DEPTH = gll_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gll_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output gll_pkg::t_cmd o_data
);
    import gll_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

// ===== hdl/gll_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gll_back
// Field evaluation pipeline, held position values and the result register.
// ----------------------------------------------------------------------------
module gll_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_have,
    input  gll_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [24:0]   o_lat_value,
    output logic [7:0]    o_lat_side,
    output logic [24:0]   o_lon_value,
    output logic [7:0]    o_lon_side,
    output logic [7:0]    o_utc_hour,
    output logic [6:0]    o_utc_minute,
    output logic [6:0]    o_utc_second,
    output logic [4:0]    o_present_mask
);
    import gll_pkg::*;

    localparam logic [24:0] SAT25   = 25'h1FFFFFF;
    localparam logic [9:0]  DEG_SAT = 10'd336;
    // ceil(2^26 / 15); exact for quotients of values below 2^22.
    localparam logic [22:0] RECIP15 = 23'd4473925;

    function automatic logic [16:0] frac_scale(input logic [2:0] cnt);
        logic [16:0] s;
        s = 17'd1;
        unique case (cnt)
            3'd0:    s = 17'd100000;
            3'd1:    s = 17'd10000;
            3'd2:    s = 17'd1000;
            3'd3:    s = 17'd100;
            3'd4:    s = 17'd10;
            default: s = 17'd1;
        endcase
        return s;
    endfunction

    logic en;
    assign en    = !o_valid || !i_stall;
    assign o_pop = en && i_have;

    // Stage 1: scale minutes and degrees.
    t_cmd        r1_cmd;
    logic        r1_v, r1_dsat;
    logic [23:0] r1_pmin;
    logic [24:0] r1_pdeg;
    logic [6:0]  mm_eff;
    logic [16:0] fr_eff;
    logic [9:0]  dg_eff;
    logic [33:0] fr_prod;
    logic [23:0] mm_prod;
    logic [25:0] dg_prod;

    always_comb begin
        mm_eff  = i_cmd.bad ? 7'd0 : i_cmd.mm;
        fr_eff  = i_cmd.bad ? 17'd0 : i_cmd.frac;
        dg_eff  = i_cmd.bad ? 10'd0 : i_cmd.deg;
        fr_prod = {17'd0, fr_eff} * {17'd0, frac_scale(i_cmd.fcnt)};
        mm_prod = {17'd0, mm_eff} * 24'd100000;
        dg_prod = {17'd0, dg_eff[8:0]} * 26'd100000;
    end

    // Stage 2: minutes over 60 as a quarter over 15.
    t_cmd        r2_cmd;
    logic        r2_v, r2_dsat;
    logic [24:0] r2_pdeg;
    logic [18:0] r2_q;
    logic [44:0] q_prod;

    assign q_prod = {23'd0, r1_pmin[23:2]} * {22'd0, RECIP15};

    // Stage 3: add, saturate and update the held values.
    logic [25:0] sum3;
    logic [24:0] coord3;
    logic [24:0] r_lat, n_lat, r_lon, n_lon;
    logic [7:0]  r_lat_side, n_lat_side, r_lon_side, n_lon_side;
    logic [7:0]  r_hr, n_hr;
    logic [6:0]  r_mn, n_mn, r_ss, n_ss;

    always_comb begin
        sum3   = {1'b0, r2_pdeg} + {7'd0, r2_q};
        coord3 = (r2_dsat || sum3 > {1'b0, SAT25}) ? SAT25 : sum3[24:0];
        n_lat = r_lat; n_lon = r_lon; n_lat_side = r_lat_side; n_lon_side = r_lon_side;
        n_hr = r_hr; n_mn = r_mn; n_ss = r_ss;
        if (r2_v) begin
            unique case (r2_cmd.fld)
                FLD_LAT:  n_lat = coord3;
                FLD_NS:   n_lat_side = r2_cmd.side;
                FLD_LON:  n_lon = coord3;
                FLD_EW:   n_lon_side = r2_cmd.side;
                FLD_TIME: begin
                    n_hr = r2_cmd.bad ? 8'd0 : r2_cmd.hr;
                    n_mn = r2_cmd.bad ? 7'd0 : r2_cmd.mn;
                    n_ss = r2_cmd.bad ? 7'd0 : r2_cmd.ss;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd  <= i_cmd;
            r1_pmin <= mm_prod + fr_prod[23:0];
            r1_pdeg <= dg_prod[24:0];
            r1_dsat <= dg_eff >= DEG_SAT;
            r2_cmd  <= r1_cmd;
            r2_pdeg <= r1_pdeg;
            r2_dsat <= r1_dsat;
            r2_q    <= q_prod[44:26];
            if (r2_v && r2_cmd.term) begin
                o_lat_value    <= n_lat;
                o_lat_side     <= n_lat_side;
                o_lon_value    <= n_lon;
                o_lon_side     <= n_lon_side;
                o_utc_hour     <= n_hr;
                o_utc_minute   <= n_mn;
                o_utc_second   <= n_ss;
                o_present_mask <= r2_cmd.mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; o_valid <= 1'b0;
            r_lat <= 25'd0; r_lon <= 25'd0; r_lat_side <= 8'd0; r_lon_side <= 8'd0;
            r_hr <= 8'd0; r_mn <= 7'd0; r_ss <= 7'd0;
        end else if (en) begin
            r1_v    <= i_have;
            r2_v    <= r1_v;
            o_valid <= r2_v && r2_cmd.term;
            r_lat <= n_lat; r_lon <= n_lon; r_lat_side <= n_lat_side;
            r_lon_side <= n_lon_side; r_hr <= n_hr; r_mn <= n_mn; r_ss <= n_ss;
        end
    end

endmodule
